// File: hw/rtl/cmss_pkg.sv
// shared types, codes and constants for the candidate map scan and suppress block
// no dependencies; used by the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package cmss_pkg;

  // default map size
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // field widths
  localparam int OP_W       = 2;
  localparam int POS_W      = 10;
  localparam int DIM_W      = 11;
  localparam int RAD_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_NEXT    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd2;

  // register reset values
  localparam logic [DIM_W-1:0] DIM_RESET    = 11'd1024;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 6'd13;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             mark;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] found_x;
    logic [POS_W-1:0] found_y;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load_wr;
    logic restart;
    logic scan_init;
    logic scan_wrap;
    logic scan_read;
    logic col_step;
    logic clr_init;
    logic clr_write;
    logic emit;
    logic emit_found;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            row_done;
    logic            col_done;
    logic            map_bit;
    logic            win_empty;
    logic            win_last;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/candidate_map_scan_and_suppress_top.sv
// from accept to result strobe the operation is decoded, then load writes the map bit and restart
// resets the scan position; remove clears the window, one map bit per cycle through the single
// write port; next reads each pixel through the registered read of the candidate memory, then
// checks it, wrapping at each row end; the result goes out through the result register
// one transaction at a time: busy drops in the cycle the result strobe shows, start may follow
// synchronous active-low reset: sizes 1024, radius 13, scan position (13, 13), no result pending
// the candidate memory is not cleared by reset; every bit must be loaded before it is scanned
`timescale 1ns / 1ps
`default_nettype none

module candidate_map_scan_and_suppress_top #(
  parameter int MAX_WIDTH  = cmss_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cmss_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // command channel
  input  wire logic                            start,
  output logic                                 busy,
  input  cmss_pkg::in_item_t                   in_item,
  // result channel, one strobe per transaction, never stalled
  output logic                                 out_valid,
  output cmss_pkg::out_item_t                  out_item,
  // register writes
  input  wire logic                            cfg_we,
  input  wire logic [cmss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cmss_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cmss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: decodes the operation and walks the scan or the window
  cmss_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // registers, counters, candidate memory and result register
  cmss_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // the controller returns to idle after each result and emits nothing there, so strobes never touch
  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes in consecutive cycles");

  // the controller goes idle exactly when the result is shown
  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("busy dropped without a result");

  // a miss or a non-scan transaction carries zero coordinates
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.found |-> (out_item.found_x == '0) && (out_item.found_y == '0))
    else $error("nonzero coordinates on a result without a hit");

endmodule

`default_nettype wire

// File: hw/rtl/cmss_ctrl.sv
// sequencing state machine for the candidate map scan and suppress block
// depends on cmss_pkg (command and status structs, operation codes)
`timescale 1ns / 1ps
`default_nettype none

module cmss_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  cmss_pkg::sts_t     sts,
  output cmss_pkg::cmd_t     cmd
);
  import cmss_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_SCAN_RD  = 3'd2;
  localparam logic [2:0] S_SCAN_CHK = 3'd3;
  localparam logic [2:0] S_CLEAR    = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_LOAD: begin
            cmd.load_wr = 1'b1;
            cmd.emit    = 1'b1;
            state_nxt   = S_IDLE;
          end
          OP_NEXT: begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN_RD;
          end
          OP_REMOVE: begin
            cmd.clr_init = 1'b1;
            state_nxt    = S_CLEAR;
          end
          OP_RESTART: begin
            cmd.restart = 1'b1;
            cmd.emit    = 1'b1;
            state_nxt   = S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SCAN_RD: begin
        if (sts.row_done) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.col_done) begin
          cmd.scan_wrap = 1'b1;
        end else begin
          cmd.scan_read = 1'b1;
          state_nxt     = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        cmd.col_step = 1'b1;
        if (sts.map_bit) begin
          cmd.emit       = 1'b1;
          cmd.emit_found = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_CLEAR: begin
        if (sts.win_empty) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.clr_write = 1'b1;
          if (sts.win_last) begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cmss_datapath.sv
// configuration registers, scan and window counters, candidate bit memory, result register
// depends on cmss_pkg (payload, command and status structs, register indexes)
`timescale 1ns / 1ps
`default_nettype none

module cmss_datapath #(
  parameter int MAX_WIDTH  = cmss_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cmss_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [cmss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cmss_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  cmss_pkg::in_item_t                   in_item,
  input  cmss_pkg::cmd_t                       cmd,
  output cmss_pkg::sts_t                       sts,
  output logic                                 out_valid,
  output cmss_pkg::out_item_t                  out_item
);
  import cmss_pkg::*;

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  // holds image sizes up to the register range, window ends and scan positions
  localparam int CW      = $clog2((1 << DIM_W) + MAX_DIM);
  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(DEPTH);

  // configuration
  logic [DIM_W-1:0] img_w_r;
  logic [DIM_W-1:0] img_h_r;
  logic [RAD_W-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r  <= DIM_RESET;
      img_h_r  <= DIM_RESET;
      radius_r <= RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w_r  <= cfg_wdata[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: img_h_r  <= cfg_wdata[DIM_W-1:0];
        CFG_RADIUS:       radius_r <= cfg_wdata[RAD_W-1:0];
        default:          ;
      endcase
    end
  end

  logic [CW-1:0] w_eff;
  logic [CW-1:0] h_eff;
  logic [CW-1:0] r_ext;

  assign w_eff = (CW'(img_w_r) > CW'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : CW'(img_w_r);
  assign h_eff = (CW'(img_h_r) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(img_h_r);
  assign r_ext = CW'(radius_r);

  // captured transaction
  in_item_t item_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
  end

  logic [CW-1:0] px;
  logic [CW-1:0] py;

  assign px = CW'(item_r.pos_x);
  assign py = CW'(item_r.pos_y);

  // scan position and bounds
  logic [CW-1:0] scan_col_r;
  logic [CW-1:0] scan_row_r;
  logic [CW-1:0] col_end_r;
  logic [CW-1:0] row_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_col_r <= CW'(RADIUS_RESET);
      scan_row_r <= CW'(RADIUS_RESET);
    end else if (cmd.restart) begin
      scan_col_r <= r_ext;
      scan_row_r <= r_ext;
    end else if (cmd.scan_wrap) begin
      scan_col_r <= r_ext;
      scan_row_r <= scan_row_r + CW'(1);
    end else if (cmd.col_step) begin
      scan_col_r <= scan_col_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      col_end_r <= (w_eff > r_ext) ? (w_eff - r_ext) : '0;
      row_end_r <= (h_eff > r_ext) ? (h_eff - r_ext) : '0;
    end
  end

  // suppression window
  logic [CW-1:0] win_x0;
  logic [CW-1:0] win_y0;
  logic [CW-1:0] win_x1t;
  logic [CW-1:0] win_y1t;
  logic [CW-1:0] win_x0_r;
  logic [CW-1:0] win_x1_r;
  logic [CW-1:0] win_y1_r;
  logic [CW-1:0] cx_r;
  logic [CW-1:0] cy_r;
  logic          win_row_end;

  assign win_x0  = (px > r_ext) ? (px - r_ext) : '0;
  assign win_y0  = (py > r_ext) ? (py - r_ext) : '0;
  assign win_x1t = px + r_ext + CW'(1);
  assign win_y1t = py + r_ext + CW'(1);

  assign win_row_end = (cx_r == (win_x1_r - CW'(1)));

  always_ff @(posedge clk) begin
    if (cmd.clr_init) begin
      win_x0_r <= win_x0;
      win_x1_r <= (win_x1t > w_eff) ? w_eff : win_x1t;
      win_y1_r <= (win_y1t > h_eff) ? h_eff : win_y1t;
      cx_r     <= win_x0;
      cy_r     <= win_y0;
    end else if (cmd.clr_write) begin
      if (win_row_end) begin
        cx_r <= win_x0_r;
        cy_r <= cy_r + CW'(1);
      end else begin
        cx_r <= cx_r + CW'(1);
      end
    end
  end

  // candidate bit memory, one write and one registered read per cycle
  logic          map_mem [DEPTH];
  logic          map_bit_r;
  logic          load_in_range;
  logic          mem_we;
  logic          mem_wd;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign load_in_range = (px < w_eff) && (py < h_eff);
  assign mem_we        = (cmd.load_wr && load_in_range) || cmd.clr_write;
  assign mem_wd        = cmd.load_wr ? item_r.mark : 1'b0;

  always_comb begin
    if (cmd.load_wr) begin
      wr_addr = AW'(py[YW-1:0]) * AW'(MAX_WIDTH) + AW'(px[XW-1:0]);
    end else begin
      wr_addr = AW'(cy_r[YW-1:0]) * AW'(MAX_WIDTH) + AW'(cx_r[XW-1:0]);
    end
  end

  assign rd_addr = AW'(scan_row_r[YW-1:0]) * AW'(MAX_WIDTH) + AW'(scan_col_r[XW-1:0]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[wr_addr] <= mem_wd;
    end
    if (cmd.scan_read) begin
      map_bit_r <= map_mem[rd_addr];
    end
  end

  // status
  assign sts.op        = item_r.op;
  assign sts.row_done  = (scan_row_r >= row_end_r);
  assign sts.col_done  = (scan_col_r >= col_end_r);
  assign sts.map_bit   = map_bit_r;
  assign sts.win_empty = (win_x0_r >= win_x1_r) || (cy_r >= win_y1_r);
  assign sts.win_last  = win_row_end && (cy_r == (win_y1_r - CW'(1)));

  // result register
  logic      out_valid_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_r.found   <= cmd.emit_found;
      out_item_r.found_x <= cmd.emit_found ? scan_col_r[POS_W-1:0] : '0;
      out_item_r.found_y <= cmd.emit_found ? scan_row_r[POS_W-1:0] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
